>>> sv/hex_world_to_pixel_defines.svh
// Assertion macros used by the hex_world_to_pixel top level.
`ifndef HEX_WORLD_TO_PIXEL_DEFINES_SVH
`define HEX_WORLD_TO_PIXEL_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HWP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay between cause and effect.
`define HWP_ASSERT_LAT(label, clk, rst_n, ante, lat, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
        else $error(msg);

`endif

>>> sv/hwp_pkg.sv
// Types, constants and width helpers shared by the hexagon pixel lookup.
`timescale 1ns / 1ps

package hwp_pkg;

    localparam int CFG_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    localparam int GRID_BITS  = 11;
    localparam int SHIFT_BITS = 23;
    localparam int INV_BITS   = 24;

    localparam int AXES   = 3;
    localparam int AXIS_Q = 0;
    localparam int AXIS_R = 1;
    localparam int AXIS_S = 2;

    // sqrt(3) with 20 fraction bits.
    localparam int               SQRT3_BITS = 21;
    localparam int               SQRT3_FRAC = 20;
    localparam logic [SQRT3_BITS-1:0] SQRT3_Q20 = 21'd1816187;

    // floor(t / 3) == (t * DIV3_MAGIC) >> DIV3_SHIFT for every 32-bit t.
    localparam int          DIV3_SHIFT = 33;
    localparam logic [31:0] DIV3_MAGIC = 32'hAAAA_AAAB;

    typedef enum logic [2:0] {
        REG_GRID_COLUMNS     = 3'd0,
        REG_GRID_ROWS        = 3'd1,
        REG_COLUMN_SHIFT     = 3'd2,
        REG_ROW_SHIFT        = 3'd3,
        REG_INVERSE_HEX_SIZE = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [GRID_BITS-1:0]  grid_columns;
        logic [GRID_BITS-1:0]  grid_rows;
        logic [SHIFT_BITS-1:0] column_shift;
        logic [SHIFT_BITS-1:0] row_shift;
        logic [INV_BITS-1:0]   inverse_hex_size;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        grid_columns:     11'd300,
        grid_rows:        11'd352,
        column_shift:     23'd489062,
        row_shift:        23'd498036,
        inverse_hex_size: 24'd2270134
    };

    // Bits dropped from the position-times-scale products.
    function automatic int red_shift(input int cb);
        return (cb > 24) ? cb - 16 : 8;
    endfunction

    // Fraction bits kept in the axial numerators.
    function automatic int frac_bits(input int cb);
        return 32 - red_shift(cb);
    endfunction

    // Shifted grid position, signed.
    function automatic int offset_width(input int cb);
        return ((cb > 24) ? cb : 24) + 1;
    endfunction

    function automatic int prod_width(input int cb);
        return offset_width(cb) + INV_BITS + 1;
    endfunction

    function automatic int axial_width(input int cb);
        return prod_width(cb) - red_shift(cb);
    endfunction

    // Numerators 3q, 3r, 3s in units of 2^-FB.
    function automatic int num_width(input int cb);
        return axial_width(cb) + 3;
    endfunction

    function automatic int quot_width(input int cb);
        return num_width(cb) - frac_bits(cb);
    endfunction

    function automatic int round_width(input int cb);
        return quot_width(cb) + 1;
    endfunction

    function automatic int err_width(input int cb);
        return frac_bits(cb) + 2;
    endfunction

endpackage

>>> sv/hwp_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module hwp_regs import hwp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_reg_idx w_idx;
    logic     w_wr;
    t_cfg     r_cfg;
    t_cfg     n_cfg;

    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_BITS-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_GRID_COLUMNS:     n_cfg.grid_columns     = pwdata[GRID_BITS-1:0];
                REG_GRID_ROWS:        n_cfg.grid_rows        = pwdata[GRID_BITS-1:0];
                REG_COLUMN_SHIFT:     n_cfg.column_shift     = pwdata[SHIFT_BITS-1:0];
                REG_ROW_SHIFT:        n_cfg.row_shift        = pwdata[SHIFT_BITS-1:0];
                REG_INVERSE_HEX_SIZE: n_cfg.inverse_hex_size = pwdata[INV_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_GRID_COLUMNS:     prdata = APB_DATA_BITS'(r_cfg.grid_columns);
            REG_GRID_ROWS:        prdata = APB_DATA_BITS'(r_cfg.grid_rows);
            REG_COLUMN_SHIFT:     prdata = APB_DATA_BITS'(r_cfg.column_shift);
            REG_ROW_SHIFT:        prdata = APB_DATA_BITS'(r_cfg.row_shift);
            REG_INVERSE_HEX_SIZE: prdata = APB_DATA_BITS'(r_cfg.inverse_hex_size);
            default:              prdata = '0;
        endcase
    end

endmodule

>>> sv/hwp_scale.sv
// Front pipeline: grid offset, scaling by the inverse size, and the 3q, 3r, 3s numerators.
`timescale 1ns / 1ps

module hwp_scale import hwp_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    input  logic signed [COORD_BITS-1:0]               i_x_pos,
    input  logic signed [COORD_BITS-1:0]               i_y_pos,
    input  t_cfg                                       i_cfg,
    output logic                                       o_valid,
    output logic signed [num_width(COORD_BITS)-1:0]    o_num [AXES]
);

    localparam int RS = red_shift(COORD_BITS);
    localparam int GW = offset_width(COORD_BITS);
    localparam int PW = prod_width(COORD_BITS);
    localparam int AW = axial_width(COORD_BITS);
    localparam int NW = num_width(COORD_BITS);
    localparam int HW = AW - SQRT3_FRAC + SQRT3_BITS + 1;
    localparam int LW = SQRT3_FRAC + SQRT3_BITS;
    localparam int MW = SQRT3_BITS;

    // Stage 1: grid offsets, y flipped.
    logic signed [GW-1:0] w_gx;
    logic signed [GW-1:0] w_gy;
    logic signed [GW-1:0] r_gx;
    logic signed [GW-1:0] r_gy;
    logic                 r_v1;

    // Stage 2: products with the inverse hexagon size.
    logic signed [INV_BITS:0] w_inv;
    logic signed [PW-1:0]     r_pa;
    logic signed [PW-1:0]     r_pb;
    logic                     r_v2;

    // Stage 3: sqrt(3) product split into a high and a low partial product.
    logic signed [AW-1:0]            w_a;
    logic signed [AW-1:0]            w_b;
    logic signed [AW-SQRT3_FRAC-1:0] w_a_hi;
    logic [SQRT3_FRAC-1:0]           w_a_lo;
    logic [LW-1:0]                   w_lo_prod;
    logic signed [HW-1:0]            r_mhi;
    logic [MW-1:0]                   r_mlo;
    logic signed [AW-1:0]            r_b;
    logic                            r_v3;

    // Stage 4: numerators.
    logic signed [NW-1:0] w_nq;
    logic signed [NW-1:0] w_nr;
    logic signed [NW-1:0] w_ns;
    logic signed [NW-1:0] w_mlo;
    logic signed [NW-1:0] r_num [AXES];
    logic                 r_v4;

    assign w_gx = GW'($signed({1'b0, i_cfg.column_shift})) + GW'(i_x_pos);
    assign w_gy = GW'($signed({1'b0, i_cfg.row_shift})) - GW'(i_y_pos);

    assign w_inv = $signed({1'b0, i_cfg.inverse_hex_size});

    // Dropping the low bits of a two's complement value floors it.
    assign w_a       = $signed(r_pa[PW-1:RS]);
    assign w_b       = $signed(r_pb[PW-1:RS]);
    assign w_a_hi    = $signed(w_a[AW-1:SQRT3_FRAC]);
    assign w_a_lo    = w_a[SQRT3_FRAC-1:0];
    assign w_lo_prod = LW'(w_a_lo) * LW'(SQRT3_Q20);

    assign w_mlo = NW'($signed({1'b0, r_mlo}));
    assign w_nq  = NW'(r_mhi) + w_mlo - NW'(r_b);
    assign w_nr  = NW'(r_b) + NW'(r_b);
    assign w_ns  = -NW'(r_mhi) - w_mlo - NW'(r_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gx          <= w_gx;
        r_gy          <= w_gy;
        r_pa          <= r_gx * w_inv;
        r_pb          <= r_gy * w_inv;
        r_mhi         <= w_a_hi * $signed({1'b0, SQRT3_Q20});
        r_mlo         <= w_lo_prod[LW-1:SQRT3_FRAC];
        r_b           <= w_b;
        r_num[AXIS_Q] <= w_nq;
        r_num[AXIS_R] <= w_nr;
        r_num[AXIS_S] <= w_ns;
    end

    assign o_valid = r_v4;
    assign o_num   = r_num;

endmodule

>>> sv/hwp_round.sv
// Three-lane rounding pipeline: nearest integer of n / (3 * 2^FB) and its rounding error.
`timescale 1ns / 1ps

module hwp_round import hwp_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic signed [num_width(COORD_BITS)-1:0]   i_num [AXES],
    output logic                                      o_valid,
    output logic signed [round_width(COORD_BITS)-1:0] o_round [AXES],
    output logic [err_width(COORD_BITS)-1:0]          o_err [AXES]
);

    localparam int NW = num_width(COORD_BITS);
    localparam int FB = frac_bits(COORD_BITS);
    localparam int TW = quot_width(COORD_BITS);
    localparam int RW = round_width(COORD_BITS);
    localparam int EW = err_width(COORD_BITS);

    // Half of one rounding unit, 1.5 * 2^FB.
    localparam logic [NW-1:0] HALF_N = NW'(3) << (FB - 1);
    localparam logic [EW-1:0] HALF_E = EW'(3) << (FB - 1);

    logic r_v5;
    logic r_v6;
    logic r_v7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v5 <= i_valid;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    assign o_valid = r_v7;

    for (genvar k = 0; k < AXES; k++) begin : g_lane
        logic [NW-1:0]        w_m;
        logic [TW-1:0]        r_t;
        logic [FB-1:0]        r_low5;
        logic                 r_neg5;
        logic [63:0]          w_prod;
        logic [TW-1:0]        r_q;
        logic [1:0]           r_tlo;
        logic [FB-1:0]        r_low6;
        logic                 r_neg6;
        logic [1:0]           w_3q;
        logic [1:0]           w_rem3;
        logic [EW-1:0]        w_rem;
        logic signed [RW-1:0] w_qs;
        logic signed [RW-1:0] r_round;
        logic [EW-1:0]        r_err;

        // Magnitude plus half a unit, in one add or subtract.
        assign w_m = i_num[k][NW-1] ? HALF_N - NW'(i_num[k]) : NW'(i_num[k]) + HALF_N;

        assign w_prod = 64'(r_t) * 64'(DIV3_MAGIC);

        // The remainder of m by 3 * 2^FB is (t mod 3) * 2^FB plus the low bits.
        assign w_3q   = r_q[1:0] + {r_q[0], 1'b0};
        assign w_rem3 = r_tlo - w_3q;
        assign w_rem  = {w_rem3, r_low6};
        assign w_qs   = $signed({1'b0, r_q});

        always_ff @(posedge i_clk) begin
            r_t     <= w_m[NW-1:FB];
            r_low5  <= w_m[FB-1:0];
            r_neg5  <= i_num[k][NW-1];
            r_q     <= w_prod[DIV3_SHIFT +: TW];
            r_tlo   <= r_t[1:0];
            r_low6  <= r_low5;
            r_neg6  <= r_neg5;
            r_round <= r_neg6 ? -w_qs : w_qs;
            r_err   <= (w_rem >= HALF_E) ? w_rem - HALF_E : HALF_E - w_rem;
        end

        assign o_round[k] = r_round;
        assign o_err[k]   = r_err;
    end

endmodule

>>> sv/hwp_select.sv
// Cube correction, even-row offset conversion and the grid bounds check.
`timescale 1ns / 1ps

module hwp_select import hwp_pkg::*; #(
    parameter int COORD_BITS = 24,
    parameter int INDEX_BITS = 10
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic signed [round_width(COORD_BITS)-1:0] i_round [AXES],
    input  logic [err_width(COORD_BITS)-1:0]          i_err [AXES],
    input  t_cfg                                      i_cfg,
    output logic                                      o_valid,
    output logic [INDEX_BITS-1:0]                     o_pixel_column,
    output logic [INDEX_BITS-1:0]                     o_pixel_row,
    output logic                                      o_out_of_grid
);

    localparam int RW = round_width(COORD_BITS);
    localparam int XW = RW + 1;
    localparam int CW = XW + 2;

    localparam logic signed [CW-1:0] IDX_LIM = CW'(1) << INDEX_BITS;

    // Stage 8: recompute the axis with the largest rounding error.
    logic signed [XW-1:0] w_rq;
    logic signed [XW-1:0] w_rr;
    logic signed [XW-1:0] w_rs;
    logic signed [XW-1:0] n_fq;
    logic signed [XW-1:0] n_fr;
    logic signed [XW-1:0] r_fq;
    logic signed [XW-1:0] r_fr;
    logic                 r_v8;

    // Stage 9: offset coordinates and bounds.
    logic signed [XW:0]   w_sum;
    logic signed [XW-1:0] w_adj;
    logic signed [CW-1:0] w_col;
    logic signed [CW-1:0] w_row;
    logic signed [CW-1:0] w_col_in;
    logic signed [CW-1:0] w_row_in;
    logic signed [CW-1:0] w_col_cap;
    logic signed [CW-1:0] w_row_cap;
    logic                 w_outside;
    logic                 r_v9;
    logic [INDEX_BITS-1:0] r_col;
    logic [INDEX_BITS-1:0] r_row;
    logic                  r_out;

    assign w_rq = XW'(i_round[AXIS_Q]);
    assign w_rr = XW'(i_round[AXIS_R]);
    assign w_rs = XW'(i_round[AXIS_S]);

    always_comb begin
        n_fq = w_rq;
        n_fr = w_rr;
        priority if (i_err[AXIS_Q] > i_err[AXIS_R] && i_err[AXIS_Q] > i_err[AXIS_S]) begin
            n_fq = -w_rr - w_rs;
        end else if (i_err[AXIS_R] > i_err[AXIS_S]) begin
            n_fr = -w_rq - w_rs;
        end else begin
            n_fq = w_rq;
        end
    end

    // column = q + (r + (r & 1)) / 2; the sum is even, so the shift is exact.
    assign w_sum = (XW + 1)'(r_fr) + $signed({{XW{1'b0}}, r_fr[0]});
    assign w_adj = $signed(w_sum[XW:1]);
    assign w_col = CW'(r_fq) + CW'(w_adj);
    assign w_row = CW'(r_fr);

    assign w_col_in  = $signed(CW'(i_cfg.grid_columns));
    assign w_row_in  = $signed(CW'(i_cfg.grid_rows));
    assign w_col_cap = (w_col_in > IDX_LIM) ? IDX_LIM : w_col_in;
    assign w_row_cap = (w_row_in > IDX_LIM) ? IDX_LIM : w_row_in;

    assign w_outside = (w_col < 0) || (w_col >= w_col_cap)
                    || (w_row < 0) || (w_row >= w_row_cap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else begin
            r_v8 <= i_valid;
            r_v9 <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fq  <= n_fq;
        r_fr  <= n_fr;
        r_out <= w_outside;
        r_col <= w_outside ? '0 : w_col[INDEX_BITS-1:0];
        r_row <= w_outside ? '0 : w_row[INDEX_BITS-1:0];
    end

    assign o_valid        = r_v9;
    assign o_pixel_column = r_col;
    assign o_pixel_row    = r_row;
    assign o_out_of_grid  = r_out;

endmodule

>>> sv/hex_world_to_pixel.sv
// Top level of the world-position to pointy-top hexagon pixel lookup.
`timescale 1ns / 1ps

// A start beat carries one world position (x, y) in mm with 16 fraction bits.
// The block answers every beat with exactly one result beat, marked by
// o_result_valid for a single cycle. It takes a new beat in every cycle,
// so busy is always low, and it has no way to hold results back: the
// receiver must take each result beat in the cycle it appears. Each beat
// runs through nine register stages: the grid offset, the multiply by the
// inverse hexagon size, the split sqrt(3) multiply, the numerator adders,
// three stages of rounding built around a reciprocal multiply for the
// divide by three, the cube correction, and the offset conversion with the
// grid check. Configuration registers are to be written over the APB-style
// port only while no beat is in flight; the block itself does not enforce
// this. They hold their reset values until first written.

`include "hex_world_to_pixel_defines.svh"

module hex_world_to_pixel import hwp_pkg::*; #(
    parameter int COORD_BITS = 24,
    parameter int INDEX_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_x_pos,
    input  logic signed [COORD_BITS-1:0] i_y_pos,
    output logic                         o_result_valid,
    output logic [INDEX_BITS-1:0]        o_pixel_column,
    output logic [INDEX_BITS-1:0]        o_pixel_row,
    output logic                         o_out_of_grid,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_BITS-1:0]     paddr,
    input  logic [APB_DATA_BITS-1:0]     pwdata,
    output logic [APB_DATA_BITS-1:0]     prdata,
    output logic                         pready
);

    localparam int NW      = num_width(COORD_BITS);
    localparam int RW      = round_width(COORD_BITS);
    localparam int EW      = err_width(COORD_BITS);
    localparam int LATENCY = 9;

    t_cfg                 w_cfg;
    logic                 w_accept;
    logic                 w_num_valid;
    logic signed [NW-1:0] w_num [AXES];
    logic                 w_round_valid;
    logic signed [RW-1:0] w_round [AXES];
    logic [EW-1:0]        w_err [AXES];

    // The pipeline never stalls, so every start beat is taken.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    hwp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Stages one to four: shift into grid space, scale, and form 3q, 3r, 3s.
    hwp_scale #(
        .COORD_BITS (COORD_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_x_pos (i_x_pos),
        .i_y_pos (i_y_pos),
        .i_cfg   (w_cfg),
        .o_valid (w_num_valid),
        .o_num   (w_num)
    );

    // Stages five to seven: round each axis and measure its error.
    hwp_round #(
        .COORD_BITS (COORD_BITS)
    ) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_num_valid),
        .i_num   (w_num),
        .o_valid (w_round_valid),
        .o_round (w_round),
        .o_err   (w_err)
    );

    // Stages eight and nine: fix the worst axis, convert, check the grid.
    hwp_select #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_select (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_round_valid),
        .i_round        (w_round),
        .i_err          (w_err),
        .i_cfg          (w_cfg),
        .o_valid        (o_result_valid),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_out_of_grid  (o_out_of_grid)
    );

    // Every accepted beat produces a result beat at the end of the pipeline.
    `HWP_ASSERT_LAT(a_result_follows, i_clk, i_rst_n, w_accept, LATENCY, o_result_valid, "result beat missing after accepted start")

    // No result beat appears without an accepted start beat to cause it.
    `HWP_ASSERT_IMP(a_result_has_cause, i_clk, i_rst_n, o_result_valid, $past(w_accept, LATENCY), "result beat without an accepted start")

    // A pixel reported inside the grid lies below the configured grid size.
    `HWP_ASSERT_IMP(a_inside_bounds, i_clk, i_rst_n, o_result_valid && !o_out_of_grid, (32'(o_pixel_column) < 32'(w_cfg.grid_columns)) && (32'(o_pixel_row) < 32'(w_cfg.grid_rows)), "in-grid pixel beyond the grid size")

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the world-position to hexagon pixel lookup.
`timescale 1ns / 1ps

module testbench;
    import hwp_pkg::*;

    localparam int COORD_BITS = 24;
    localparam int INDEX_BITS = 10;

    // Product reduction and numerator fraction bits at this coordinate width.
    localparam int RED_SHIFT = (COORD_BITS > 24) ? COORD_BITS - 16 : 8;
    localparam int FRAC_BITS = 32 - RED_SHIFT;

    // Grid sizes beyond the index range behave as the full index range.
    localparam longint GRID_LIMIT = longint'(1) << INDEX_BITS;

    // Pipeline depth of the block, used for the settling margins.
    localparam int LATENCY = 9;

    // Cycle budget for the whole run, far above the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;

    // Random part: phases of configuration, each with its own batch of beats.
    localparam int PHASES = 8;
    localparam int BEATS_PER_PHASE = 250;
    localparam int QUIET_PHASE = 5;

    // A register index past the end of the map; writes to it must be dropped.
    localparam logic [2:0] UNMAPPED_REG = 3'd5;

    localparam logic signed [COORD_BITS-1:0] X_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] X_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [INDEX_BITS-1:0] column;
        logic [INDEX_BITS-1:0] row;
        logic                  off_grid;
    } t_pixel;

    typedef struct {
        int     beat;
        t_pixel pixel;
    } t_pending;

    typedef enum logic [1:0] {
        ROW_BEAT,
        ROW_CHECKED_BEAT,
        ROW_REG_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [2:0]                    reg_idx;
        logic [31:0]                   value;
        logic signed [COORD_BITS-1:0]  x_pos;
        logic signed [COORD_BITS-1:0]  y_pos;
        t_pixel                        pixel;
    } t_stim_row;

    logic                         i_clk;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [COORD_BITS-1:0] i_x_pos = '0;
    logic signed [COORD_BITS-1:0] i_y_pos = '0;
    logic                         o_result_valid;
    logic [INDEX_BITS-1:0]        o_pixel_column;
    logic [INDEX_BITS-1:0]        o_pixel_row;
    logic                         o_out_of_grid;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0]     paddr = '0;
    logic [APB_DATA_BITS-1:0]     pwdata = '0;
    logic [APB_DATA_BITS-1:0]     prdata;
    logic                         pready;

    // The grid setup as the block should currently hold it.
    t_cfg      grid_cfg = CFG_RESET;
    t_pending  pending_pixels[$];
    t_stim_row directed_rows[$];
    int        mismatch_count = 0;
    int        beat_count = 0;
    int        cycle_count = 0;

    hex_world_to_pixel #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_x_pos        (i_x_pos),
        .i_y_pos        (i_y_pos),
        .o_result_valid (o_result_valid),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_out_of_grid  (o_out_of_grid),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Nearest integer to n / d with halves going away from zero; d is positive.
    function automatic longint round_nearest(input longint n, input longint d);
        if (n >= 0) begin
            return (n + d / 2) / d;
        end
        return -((-n + d / 2) / d);
    endfunction

    // Predicts the pixel for one world position under the current grid setup.
    // The numerators are three times q, r and s with FRAC_BITS fraction bits,
    // so every comparison of rounding errors below is exact.
    function automatic t_pixel locate_hexagon(input logic signed [COORD_BITS-1:0] x_pos,
                                              input logic signed [COORD_BITS-1:0] y_pos);
        longint unit, inv, gx, gy, prod_x, prod_y, nq, nr, ns;
        longint rq, rr, rs, eq, er, es, col, row, ncol, nrow;
        t_pixel res;
        unit = longint'(3) << FRAC_BITS;
        inv = longint'(grid_cfg.inverse_hex_size);
        gx = longint'(grid_cfg.column_shift) + longint'(x_pos);
        gy = longint'(grid_cfg.row_shift) - longint'(y_pos);
        prod_x = (gx * inv) >>> RED_SHIFT;
        prod_y = (gy * inv) >>> RED_SHIFT;
        nq = ((prod_x * longint'(SQRT3_Q20)) >>> SQRT3_FRAC) - prod_y;
        nr = 2 * prod_y;
        ns = -nq - nr;
        rq = round_nearest(nq, unit);
        rr = round_nearest(nr, unit);
        rs = round_nearest(ns, unit);
        eq = nq - rq * unit;
        er = nr - rr * unit;
        es = ns - rs * unit;
        if (eq < 0) eq = -eq;
        if (er < 0) er = -er;
        if (es < 0) es = -es;
        // Cube rounding: the axis that rounded worst is rebuilt from the others.
        if (eq > er && eq > es) begin
            rq = -rr - rs;
        end else if (er > es) begin
            rr = -rq - rs;
        end
        // Even-row offset: even rows are pushed half a column to the right.
        row = rr;
        col = rq + ((rr + (rr & 1)) >>> 1);
        ncol = longint'(grid_cfg.grid_columns);
        nrow = longint'(grid_cfg.grid_rows);
        if (ncol > GRID_LIMIT) ncol = GRID_LIMIT;
        if (nrow > GRID_LIMIT) nrow = GRID_LIMIT;
        if (col >= 0 && col < ncol && row >= 0 && row < nrow) begin
            res.column   = col[INDEX_BITS-1:0];
            res.row      = row[INDEX_BITS-1:0];
            res.off_grid = 1'b0;
        end else begin
            res = '{column: '0, row: '0, off_grid: 1'b1};
        end
        return res;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
        if (v > longint'(X_MAX)) return X_MAX;
        if (v < longint'(X_MIN)) return X_MIN;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic t_stim_row table_beat(input logic signed [COORD_BITS-1:0] x_pos,
                                             input logic signed [COORD_BITS-1:0] y_pos);
        return '{kind: ROW_BEAT, reg_idx: '0, value: '0, x_pos: x_pos, y_pos: y_pos,
                 pixel: '0};
    endfunction

    function automatic t_stim_row table_checked(input logic signed [COORD_BITS-1:0] x_pos,
                                                input logic signed [COORD_BITS-1:0] y_pos,
                                                input t_pixel pixel);
        return '{kind: ROW_CHECKED_BEAT, reg_idx: '0, value: '0, x_pos: x_pos,
                 y_pos: y_pos, pixel: pixel};
    endfunction

    function automatic t_stim_row table_write(input logic [2:0] reg_idx,
                                              input logic [31:0] value);
        return '{kind: ROW_REG_WRITE, reg_idx: reg_idx, value: value, x_pos: '0,
                 y_pos: '0, pixel: '0};
    endfunction

    task automatic report_mismatch(input int beat, input string field,
                                   input longint got, input longint want);
        $display("mismatch: beat %0d %s got %0d expected %0d", beat, field, got, want);
        mismatch_count++;
    endtask

    // Waits until every result beat has come back and the pipeline has emptied,
    // so that no beat is in flight when a register changes.
    task automatic settle();
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // One APB write: a setup phase, then an access phase held until pready,
    // then an idle phase so that the next write starts from a clean bus.
    // The predictor takes the new value the same way the register should.
    task automatic write_reg(input logic [2:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_GRID_COLUMNS:     grid_cfg.grid_columns     = value[GRID_BITS-1:0];
            REG_GRID_ROWS:        grid_cfg.grid_rows        = value[GRID_BITS-1:0];
            REG_COLUMN_SHIFT:     grid_cfg.column_shift     = value[SHIFT_BITS-1:0];
            REG_ROW_SHIFT:        grid_cfg.row_shift        = value[SHIFT_BITS-1:0];
            REG_INVERSE_HEX_SIZE: grid_cfg.inverse_hex_size = value[INV_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_grid(input logic [31:0] cols, input logic [31:0] rows,
                              input logic [31:0] col_shift, input logic [31:0] row_shift,
                              input logic [31:0] inv_size);
        settle();
        write_reg(REG_GRID_COLUMNS, cols);
        write_reg(REG_GRID_ROWS, rows);
        write_reg(REG_COLUMN_SHIFT, col_shift);
        write_reg(REG_ROW_SHIFT, row_shift);
        write_reg(REG_INVERSE_HEX_SIZE, inv_size);
        write_reg(UNMAPPED_REG, $urandom);
    endtask

    // Presents one start beat and holds it until the block takes it. The
    // expected pixel is queued at the accepting edge, either typed in by the
    // caller or worked out by the predictor. A random gap may follow.
    task automatic send_position(input logic signed [COORD_BITS-1:0] x_pos,
                                 input logic signed [COORD_BITS-1:0] y_pos,
                                 input bit typed, input t_pixel typed_pixel,
                                 input bit may_idle);
        t_pending entry;
        start   <= 1'b1;
        i_x_pos <= x_pos;
        i_y_pos <= y_pos;
        do @(posedge i_clk); while (busy);
        entry.beat  = beat_count;
        entry.pixel = typed ? typed_pixel : locate_hexagon(x_pos, y_pos);
        pending_pixels.push_back(entry);
        beat_count++;
        if (may_idle && $urandom_range(0, 99) < 11) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Most random positions land on or near the grid so that real pixels come
    // back; the rest are drawn over the whole coordinate range. The grid span
    // is estimated from the hexagon radius, which is 2^32 / inverse_hex_size
    // in the position's own units.
    task automatic pick_position(output logic signed [COORD_BITS-1:0] x_pos,
                                 output logic signed [COORD_BITS-1:0] y_pos);
        longint radius, ncol, nrow, span_x, span_y, gx, gy;
        if (grid_cfg.inverse_hex_size == 0 || $urandom_range(0, 99) < 30) begin
            x_pos = COORD_BITS'($urandom);
            y_pos = COORD_BITS'($urandom);
        end else begin
            radius = (longint'(1) << 32) / longint'(grid_cfg.inverse_hex_size);
            ncol = longint'(grid_cfg.grid_columns);
            nrow = longint'(grid_cfg.grid_rows);
            if (ncol > GRID_LIMIT) ncol = GRID_LIMIT;
            if (nrow > GRID_LIMIT) nrow = GRID_LIMIT;
            span_x = ncol * radius * 1774 / 1024 + 2 * radius;
            span_y = nrow * radius * 3 / 2 + 2 * radius;
            if (span_x > GRID_LIMIT << 14) span_x = GRID_LIMIT << 14;
            if (span_y > GRID_LIMIT << 14) span_y = GRID_LIMIT << 14;
            gx = longint'($urandom_range(0, 32'(span_x + span_x / 8))) - span_x / 16 - radius;
            gy = longint'($urandom_range(0, 32'(span_y + span_y / 8))) - span_y / 16 - radius;
            x_pos = clamp_coord(gx - longint'(grid_cfg.column_shift));
            y_pos = clamp_coord(longint'(grid_cfg.row_shift) - gy);
        end
    endtask

    // Each result beat is on the ports for one cycle and is taken at the edge
    // that ends it; it is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_pending want;
        if (i_rst_n && o_result_valid) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch(-1, "unexpected result beat", 1, 0);
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_column !== want.pixel.column) begin
                    report_mismatch(want.beat, "pixel_column", o_pixel_column,
                                    want.pixel.column);
                end
                if (o_pixel_row !== want.pixel.row) begin
                    report_mismatch(want.beat, "pixel_row", o_pixel_row, want.pixel.row);
                end
                if (o_out_of_grid !== want.pixel.off_grid) begin
                    report_mismatch(want.beat, "out_of_grid", o_out_of_grid,
                                    want.pixel.off_grid);
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic signed [COORD_BITS-1:0] x_pos;
        logic signed [COORD_BITS-1:0] y_pos;
        t_stim_row row;
        logic [31:0] inv_size;

        // Directed part. The first beats run on the reset setup. A point at
        // the grid origin lands on pixel (0, 0), and the coordinate extremes
        // fall far outside the default grid.
        directed_rows.push_back(table_beat('0, '0));
        directed_rows.push_back(table_checked(X_MAX, X_MIN, '{0, 0, 1}));
        directed_rows.push_back(table_checked(X_MIN, X_MAX, '{0, 0, 1}));
        directed_rows.push_back(table_beat(X_MAX, X_MAX));
        directed_rows.push_back(table_beat(X_MIN, X_MIN));
        directed_rows.push_back(table_checked(-24'sd489062, 24'sd498036, '{0, 0, 0}));
        directed_rows.push_back(table_beat(-24'sd1, -24'sd1));
        // With a zero inverse size every point collapses onto pixel (0, 0).
        directed_rows.push_back(table_write(REG_INVERSE_HEX_SIZE, 32'd0));
        directed_rows.push_back(table_checked(24'sd12345, -24'sd6789, '{0, 0, 0}));
        directed_rows.push_back(table_checked(X_MAX, X_MIN, '{0, 0, 0}));
        // A zero grid size in either direction puts every point off the grid.
        directed_rows.push_back(table_write(REG_INVERSE_HEX_SIZE, 32'd2270134));
        directed_rows.push_back(table_write(REG_GRID_COLUMNS, 32'd0));
        directed_rows.push_back(table_checked(-24'sd489062, 24'sd498036, '{0, 0, 1}));
        directed_rows.push_back(table_write(REG_GRID_COLUMNS, 32'd300));
        directed_rows.push_back(table_write(REG_GRID_ROWS, 32'd0));
        directed_rows.push_back(table_checked(-24'sd489062, 24'sd498036, '{0, 0, 1}));
        // Grid sizes past the index range, with the smallest hexagons: rows
        // around 1024 show where the size is cut back to the index range.
        directed_rows.push_back(table_write(REG_GRID_ROWS, 32'd2047));
        directed_rows.push_back(table_write(REG_GRID_COLUMNS, 32'd2047));
        directed_rows.push_back(table_write(REG_COLUMN_SHIFT, 32'd0));
        directed_rows.push_back(table_write(REG_ROW_SHIFT, 32'd0));
        directed_rows.push_back(table_write(REG_INVERSE_HEX_SIZE, 32'hFFFF_FFFF));
        directed_rows.push_back(table_beat(24'sd100000, -24'sd392000));
        directed_rows.push_back(table_beat(24'sd100000, -24'sd393300));
        directed_rows.push_back(table_beat(24'sd100000, -24'sd394000));
        directed_rows.push_back(table_beat(24'sd443000, -24'sd1000));
        // A write past the register map changes nothing.
        directed_rows.push_back(table_write(UNMAPPED_REG, 32'd0));
        directed_rows.push_back(table_beat(24'sd100000, -24'sd392000));
        // A single-pixel grid.
        directed_rows.push_back(table_write(REG_GRID_COLUMNS, 32'd1));
        directed_rows.push_back(table_write(REG_GRID_ROWS, 32'd1));
        directed_rows.push_back(table_write(REG_INVERSE_HEX_SIZE, 32'd2270134));
        directed_rows.push_back(table_checked('0, '0, '{0, 0, 0}));
        directed_rows.push_back(table_beat(24'sd4000, '0));
        directed_rows.push_back(table_beat(-24'sd1500, 24'sd1500));
        directed_rows.push_back(table_beat(24'sd1900, -24'sd1900));

        // Synchronous reset, held low from time zero.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_REG_WRITE) begin
                settle();
                write_reg(row.reg_idx, row.value);
            end else begin
                send_position(row.x_pos, row.y_pos, row.kind == ROW_CHECKED_BEAT,
                              row.pixel, 1'b1);
            end
        end

        // Random part: each phase writes a whole grid setup, the reset setup
        // first, then the extremes, then random ones. One phase runs without any gap at all.
        for (int phase = 0; phase < PHASES; phase++) begin
            inv_size = $urandom_range(1, 32'hFF_FFFF) >> $urandom_range(0, 8);
            case (phase)
                0: write_grid(32'd300, 32'd352, 32'd489062, 32'd498036, 32'd2270134);
                1: write_grid(32'd1024, 32'd1024, 32'h7F_FFFF, 32'h7F_FFFF, 32'hFF_FFFF);
                2: write_grid(32'd2047, 32'd2047, 32'd0, 32'd0, 32'd1);
                3: write_grid(32'd1, 32'd1, $urandom, $urandom, inv_size);
                default: write_grid($urandom_range(1, 1024), $urandom_range(1, 1024),
                                    $urandom, $urandom, inv_size);
            endcase
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                pick_position(x_pos, y_pos);
                send_position(x_pos, y_pos, 1'b0, '0, phase != QUIET_PHASE);
            end
        end

        // Drain: every expected result beat, then a margin past the pipeline.
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
